// ===== sv/eitn_pkg.sv =====
`default_nettype none
package eitn_pkg;

    // Whole-character key: byte count above the character bytes
    typedef logic [34:0] t_key;

    typedef struct packed {
        logic sp;     // space class: first byte <= 0x20, or underscore
        logic qt;     // quote class
        logic dl;     // any delimiter, spaces included
        logic hard;   // delimiter that is neither space nor quote
    } t_class;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
        logic        last;
    } t_res;

    localparam int DelimCount = 23;
    localparam int QuoteCount = 7;

    localparam logic [7:0] SEP_SPACE = 8'h5F;
    localparam logic [7:0] SEP_HARD  = 8'h2D;
    localparam logic [7:0] SPACE_MAX = 8'h20;
    localparam logic [2:0] MAX_LEN   = 3'd4;

    localparam t_key DELIM_TAB [DelimCount] = '{
        {3'd1, 32'h0000_0022}, {3'd3, 32'h0099_80E2}, {3'd1, 32'h0000_0060},
        {3'd1, 32'h0000_0027}, {3'd1, 32'h0000_003F}, {3'd1, 32'h0000_0021},
        {3'd1, 32'h0000_002F}, {3'd1, 32'h0000_003B}, {3'd1, 32'h0000_003A},
        {3'd1, 32'h0000_002E}, {3'd1, 32'h0000_002C}, {3'd1, 32'h0000_002D},
        {3'd3, 32'h0094_80E2}, {3'd1, 32'h0000_0020}, {3'd1, 32'h0000_0029},
        {3'd1, 32'h0000_0028}, {3'd1, 32'h0000_005B}, {3'd1, 32'h0000_005D},
        {3'd1, 32'h0000_007B}, {3'd1, 32'h0000_007D}, {3'd1, 32'h0000_003C},
        {3'd1, 32'h0000_003E}, {3'd1, 32'h0000_005F}
    };

    localparam t_key QUOTE_TAB [QuoteCount] = '{
        {3'd1, 32'h0000_0022}, {3'd1, 32'h0000_0027}, {3'd3, 32'h0099_80E2},
        {3'd1, 32'h0000_0060}, {3'd1, 32'h0000_003B}, {3'd1, 32'h0000_002E},
        {3'd1, 32'h0000_003A}
    };

    // Result queue
    localparam int FifoDepth = 4;
    localparam int FifoPw    = $clog2(FifoDepth);
    localparam int FifoCw    = $clog2(FifoDepth + 1);

    function automatic logic in_delim(input t_key key);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < DelimCount; i++) begin
            hit = hit | (DELIM_TAB[i] == key);
        end
        return hit;
    endfunction

    function automatic logic in_quote(input t_key key);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < QuoteCount; i++) begin
            hit = hit | (QUOTE_TAB[i] == key);
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// ===== sv/eitn_classify.sv =====
`default_nettype none
// Clamps the length, clears unused bytes and classifies the character.
module eitn_classify (
    input  wire logic [31:0]    i_char_bytes,
    input  wire logic [2:0]     i_char_len,
    output logic [31:0]         o_bytes,
    output logic [2:0]          o_len,
    output eitn_pkg::t_class    o_class
);

    eitn_pkg::t_key key;
    logic           sp;
    logic           qt;
    logic           dl;

    always_comb begin
        o_len = (i_char_len > eitn_pkg::MAX_LEN) ? eitn_pkg::MAX_LEN : i_char_len;
        case (o_len)
            3'd0:    o_bytes = 32'h0;
            3'd1:    o_bytes = {24'h0, i_char_bytes[7:0]};
            3'd2:    o_bytes = {16'h0, i_char_bytes[15:0]};
            3'd3:    o_bytes = {8'h0, i_char_bytes[23:0]};
            default: o_bytes = i_char_bytes;
        endcase
    end

    assign key = {o_len, o_bytes};
    assign sp  = (o_bytes[7:0] <= eitn_pkg::SPACE_MAX) || (o_bytes[7:0] == eitn_pkg::SEP_SPACE);
    assign qt  = eitn_pkg::in_quote(key);
    assign dl  = sp | eitn_pkg::in_delim(key);

    assign o_class = '{sp: sp, qt: qt, dl: dl, hard: dl & ~sp & ~qt};

endmodule
`default_nettype wire

// ===== sv/entity_id_text_normalizer.sv =====
`default_nettype none
// Entity-id normaliser. One UTF-8 character per input transfer (bytes, length,
// last), producing the entity-id form on the output channel one character per
// transfer. Leading quotes and spaces are dropped; each run of spaces and
// delimiters becomes a single '_' (spaces only) or '-' (any other delimiter);
// a trailing run gives '-' only when it holds a hard delimiter. The transfer
// with last set always yields one result with out_last set, possibly empty
// (out_len 0). Lengths above 4 count as 4; bytes past the length are emitted
// as zero. Input transfers are taken every cycle while the output keeps up;
// a character that closes a run yields two results, so the output channel
// (one result per cycle while i_stall is low) sets the sustained rate. Each
// character passes an input register, then a four-entry result queue whose
// head drives the outputs.
module entity_id_text_normalizer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [31:0]    i_char_bytes,
    input  wire logic [2:0]     i_char_len,
    input  wire logic           i_last,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [31:0]         o_out_bytes,
    output logic [2:0]          o_out_len,
    output logic                o_out_last
);

    // ---- input register ----
    logic           r_in_valid, n_in_valid;
    logic [31:0]    r_bytes;
    logic [2:0]     r_len;
    logic           r_last;

    // ---- run state ----
    logic r_at_start, n_at_start;
    logic r_run_open, n_run_open;
    logic r_run_sp,   n_run_sp;     // run holds spaces only
    logic r_run_hard, n_run_hard;   // run holds a hard delimiter

    // ---- result queue ----
    eitn_pkg::t_res                 r_fifo [eitn_pkg::FifoDepth];
    logic [eitn_pkg::FifoPw-1:0]    r_wp, n_wp;
    logic [eitn_pkg::FifoPw-1:0]    r_rp, n_rp;
    logic [eitn_pkg::FifoCw-1:0]    r_count, n_count;

    logic [31:0]        c_bytes;
    logic [2:0]         c_len;
    eitn_pkg::t_class   c_cls;

    logic               in_xfer;
    logic               out_xfer;
    logic               room;
    logic               fire;
    logic [1:0]         n_res;
    eitn_pkg::t_res     res0, res1;

    eitn_classify u_classify (
        .i_char_bytes (r_bytes),
        .i_char_len   (r_len),
        .o_bytes      (c_bytes),
        .o_len        (c_len),
        .o_class      (c_cls)
    );

    // Room for the worst case of two results, judged on the registered count
    assign room     = (r_count <= eitn_pkg::FifoCw'(eitn_pkg::FifoDepth - 2));
    assign fire     = r_in_valid & room;
    assign o_stall  = r_in_valid & ~room;
    assign in_xfer  = i_valid & ~o_stall;
    assign o_valid  = (r_count != '0);
    assign out_xfer = o_valid & ~i_stall;

    assign o_out_bytes = r_fifo[r_rp].bytes;
    assign o_out_len   = r_fifo[r_rp].len;
    assign o_out_last  = r_fifo[r_rp].last;

    assign n_in_valid = in_xfer | (r_in_valid & ~fire);

    // Character processing and flag update
    always_comb begin
        logic end_open, end_hard;
        n_at_start = r_at_start;
        n_run_open = r_run_open;
        n_run_sp   = r_run_sp;
        n_run_hard = r_run_hard;
        n_res      = 2'd0;
        res0       = '{bytes: 32'h0, len: 3'd0, last: 1'b1};
        res1       = '{bytes: c_bytes, len: c_len, last: r_last};
        end_open   = r_run_open;
        end_hard   = r_run_hard;

        if (fire) begin
            if (c_len != 3'd0 && !(r_at_start && (c_cls.sp || c_cls.qt)) && !c_cls.dl) begin
                // ordinary character, closing any open run first
                n_at_start = 1'b0;
                n_run_open = 1'b0;
                n_run_sp   = 1'b1;
                n_run_hard = 1'b0;
                if (r_run_open) begin
                    res0  = '{bytes: {24'h0, r_run_sp ? eitn_pkg::SEP_SPACE : eitn_pkg::SEP_HARD},
                              len: 3'd1, last: 1'b0};
                    n_res = 2'd2;
                end else begin
                    res0  = res1;
                    n_res = 2'd1;
                end
                if (r_last) begin
                    n_at_start = 1'b1;
                end
            end else begin
                if (c_len != 3'd0 && !(r_at_start && (c_cls.sp || c_cls.qt))) begin
                    // delimiter extends or opens a run
                    n_at_start = 1'b0;
                    n_run_open = 1'b1;
                    n_run_sp   = r_run_open ? (r_run_sp & c_cls.sp)     : c_cls.sp;
                    n_run_hard = r_run_open ? (r_run_hard | c_cls.hard) : c_cls.hard;
                    end_open   = 1'b1;
                    end_hard   = n_run_hard;
                end
                if (r_last) begin
                    if (end_open && end_hard) begin
                        res0 = '{bytes: {24'h0, eitn_pkg::SEP_HARD}, len: 3'd1, last: 1'b1};
                    end
                    n_res      = 2'd1;
                    n_at_start = 1'b1;
                    n_run_open = 1'b0;
                    n_run_sp   = 1'b1;
                    n_run_hard = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_wp    = r_wp + eitn_pkg::FifoPw'(n_res);
        n_rp    = out_xfer ? (r_rp + eitn_pkg::FifoPw'(1)) : r_rp;
        n_count = r_count + eitn_pkg::FifoCw'(n_res) - eitn_pkg::FifoCw'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_at_start <= 1'b1;
            r_run_open <= 1'b0;
            r_run_sp   <= 1'b1;
            r_run_hard <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_at_start <= n_at_start;
            r_run_open <= n_run_open;
            r_run_sp   <= n_run_sp;
            r_run_hard <= n_run_hard;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_count    <= n_count;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_bytes <= i_char_bytes;
            r_len   <= i_char_len;
            r_last  <= i_last;
        end
        if (n_res != 2'd0) begin
            r_fifo[r_wp] <= res0;
        end
        if (n_res == 2'd2) begin
            r_fifo[r_wp + eitn_pkg::FifoPw'(1)] <= res1;
        end
    end

    // ---- assertions ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= eitn_pkg::FifoCw'(eitn_pkg::FifoDepth))
        else $error("result queue overfilled");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_last |=> r_at_start && !r_run_open)
        else $error("state not cleared after end of string");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_len == 3'd0) |-> o_out_last)
        else $error("empty result not marked last");

    a_run_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_open |-> !r_at_start)
        else $error("run open during leading trim");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_len <= eitn_pkg::MAX_LEN)
        else $error("result length out of range");

endmodule
`default_nettype wire
